// ----- design/dmrc_pkg.sv -----
// Shared widths, item type and saturation helper for the diffusion row coefficient block.
`default_nettype none
package dmrc_pkg;

  localparam int WordBits  = 48;
  localparam int FracBits  = 32;
  localparam int MagBits   = WordBits - 1;
  localparam int HalfBits  = (MagBits + 1) / 2;
  localparam int ProdBits  = 2 * MagBits;
  localparam int QuotBits  = MagBits;
  localparam int MulLat    = 2;
  localparam int DivLat    = QuotBits + 1;
  localparam int PipeLat   = 2 * MulLat + 2 * DivLat;
  localparam int HarmNum   = ProdBits;
  localparam int HarmDen   = MagBits + 1;
  localparam int CoupNum   = ProdBits + 1 + FracBits;
  localparam int CoupDen   = ProdBits;

  localparam logic [MagBits-1:0] CellWidthReset = MagBits'(64'd1 << FracBits);

  typedef enum logic {
    FUNC_INTERIOR = 1'b0,
    FUNC_BOUNDARY = 1'b1
  } func_e;

  typedef struct packed {
    func_e                func;
    logic                 err;
    logic                 has_left;
    logic [MagBits-1:0]   ds;
    logic [MagBits-1:0]   dr;
    logic [MagBits-1:0]   dl;
    logic [MagBits-1:0]   rem;
    logic [MagBits-1:0]   vol;
    logic [MagBits-1:0]   al;
    logic [MagBits-1:0]   ar;
    logic [MagBits-1:0]   cw;
    logic [MagBits:0]     sum_r;
    logic [MagBits:0]     sum_l;
    logic                 a_neg;
    logic [MagBits-1:0]   a_half;
    logic                 b_neg;
    logic [WordBits-1:0]  b_mag;
  } item_t;

  function automatic logic [WordBits-1:0] sat_word(input logic signed [WordBits:0] x);
    logic signed [WordBits:0] hi;
    logic signed [WordBits:0] lo;
    hi = $signed({2'b00, {MagBits{1'b1}}});
    lo = $signed({2'b11, {MagBits{1'b0}}});
    if (x > hi) begin
      return {1'b0, {MagBits{1'b1}}};
    end else if (x < lo) begin
      return {1'b1, {MagBits{1'b0}}};
    end else begin
      return x[WordBits-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- design/dmrc_mul.sv -----
// Two-stage unsigned multiplier built from four half-width partial products.
`default_nettype none
module dmrc_mul (
  input  logic                          clk_i,
  input  logic [dmrc_pkg::MagBits-1:0]  a_i,
  input  logic [dmrc_pkg::MagBits-1:0]  b_i,
  output logic [dmrc_pkg::ProdBits-1:0] prod_o
);
  localparam int HB = dmrc_pkg::HalfBits;
  localparam int MB = dmrc_pkg::MagBits;
  localparam int PB = dmrc_pkg::ProdBits;
  localparam int PpBits = 2 * HB;

  logic [PpBits-1:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic [PB-1:0]     prod_q;

  always_ff @(posedge clk_i) begin
    pp_ll_q <= PpBits'(a_i[HB-1:0])  * PpBits'(b_i[HB-1:0]);
    pp_lh_q <= PpBits'(a_i[HB-1:0])  * PpBits'(b_i[MB-1:HB]);
    pp_hl_q <= PpBits'(a_i[MB-1:HB]) * PpBits'(b_i[HB-1:0]);
    pp_hh_q <= PpBits'(a_i[MB-1:HB]) * PpBits'(b_i[MB-1:HB]);
    prod_q  <= PB'(pp_ll_q) + ((PB'(pp_lh_q) + PB'(pp_hl_q)) << HB) + (PB'(pp_hh_q) << (2 * HB));
  end

  assign prod_o = prod_q;
endmodule
`default_nettype wire

// ----- design/dmrc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
`default_nettype none
module dmrc_div #(
  parameter int NumBits = dmrc_pkg::HarmNum,
  parameter int DenBits = dmrc_pkg::HarmDen
) (
  input  logic                          clk_i,
  input  logic [NumBits-1:0]            num_i,
  input  logic [DenBits-1:0]            den_i,
  output logic [dmrc_pkg::QuotBits-1:0] quo_o
);
  localparam int QB      = dmrc_pkg::QuotBits;
  localparam int TopBits = NumBits - QB;
  localparam int CmpBits = (TopBits > DenBits) ? TopBits : DenBits;

  logic [DenBits-1:0] rem_q [QB+1];
  logic [QB-1:0]      low_q [QB+1];
  logic [QB-1:0]      quo_q [QB+1];
  logic               sat_q [QB+1];
  logic [DenBits-1:0] den_q [QB+1];
  logic [DenBits:0]   trial [QB];
  logic               ge    [QB];
  logic [DenBits-1:0] nrem  [QB];

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      trial[k] = {rem_q[k], low_q[k][QB-1]};
      ge[k]    = trial[k] >= {1'b0, den_q[k]};
      nrem[k]  = ge[k] ? DenBits'(trial[k] - {1'b0, den_q[k]}) : DenBits'(trial[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= DenBits'(num_i[NumBits-1:QB]);
    low_q[0] <= num_i[QB-1:0];
    quo_q[0] <= '0;
    sat_q[0] <= CmpBits'(num_i[NumBits-1:QB]) >= CmpBits'(den_i);
    den_q[0] <= den_i;
    for (int k = 0; k < QB; k++) begin
      rem_q[k+1] <= nrem[k];
      low_q[k+1] <= low_q[k] << 1;
      quo_q[k+1] <= {quo_q[k][QB-2:0], ge[k]};
      sat_q[k+1] <= sat_q[k];
      den_q[k+1] <= den_q[k];
    end
  end

  assign quo_o = sat_q[QB] ? {QB{1'b1}} : quo_q[QB];
endmodule
`default_nettype wire

// ----- design/dmrc_front.sv -----
// Front end: classifies a row, detects zero divisors and forms operand magnitudes.
`default_nettype none
module dmrc_front (
  input  logic                                func_i,
  input  logic [dmrc_pkg::MagBits-1:0]        diff_self_i,
  input  logic [dmrc_pkg::MagBits-1:0]        diff_right_i,
  input  logic [dmrc_pkg::MagBits-1:0]        diff_left_i,
  input  logic [dmrc_pkg::MagBits-1:0]        removal_xs_i,
  input  logic [dmrc_pkg::MagBits-1:0]        cell_volume_i,
  input  logic [dmrc_pkg::MagBits-1:0]        area_left_i,
  input  logic [dmrc_pkg::MagBits-1:0]        area_right_i,
  input  logic                                has_left_i,
  input  logic signed [dmrc_pkg::WordBits-1:0] bc_a_i,
  input  logic signed [dmrc_pkg::WordBits-1:0] bc_b_i,
  input  logic [dmrc_pkg::MagBits-1:0]        cell_width_i,
  output dmrc_pkg::item_t                     item_o
);
  localparam int WB = dmrc_pkg::WordBits;
  localparam int MB = dmrc_pkg::MagBits;

  logic [WB-1:0] a_mag;
  logic [MB:0]   sum_r, sum_l;
  logic          cw_zero, int_err;

  always_comb begin
    a_mag   = bc_a_i[WB-1] ? (~bc_a_i + 1'b1) : bc_a_i;
    sum_r   = {1'b0, diff_self_i} + {1'b0, diff_right_i};
    sum_l   = {1'b0, diff_self_i} + {1'b0, diff_left_i};
    cw_zero = cell_width_i == '0;
    int_err = cw_zero || (cell_volume_i == '0) || (sum_r == '0) ||
              (has_left_i && (sum_l == '0));

    item_o.func     = dmrc_pkg::func_e'(func_i);
    item_o.err      = (dmrc_pkg::func_e'(func_i) == dmrc_pkg::FUNC_INTERIOR) ? int_err : cw_zero;
    item_o.has_left = has_left_i;
    item_o.ds       = diff_self_i;
    item_o.dr       = diff_right_i;
    item_o.dl       = diff_left_i;
    item_o.rem      = removal_xs_i;
    item_o.vol      = cell_volume_i;
    item_o.al       = area_left_i;
    item_o.ar       = area_right_i;
    item_o.cw       = cell_width_i;
    item_o.sum_r    = sum_r;
    item_o.sum_l    = sum_l;
    item_o.a_neg    = bc_a_i[WB-1];
    item_o.a_half   = a_mag[WB-1:1];
    item_o.b_neg    = bc_b_i[WB-1];
    item_o.b_mag    = bc_b_i[WB-1] ? (~bc_b_i + 1'b1) : bc_b_i;
  end
endmodule
`default_nettype wire

// ----- design/dmrc_queue.sv -----
// Two-word queue between front and back; the back drains it every cycle.
`default_nettype none
module dmrc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dmrc_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  output dmrc_pkg::item_t item_o
);
  dmrc_pkg::item_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            pop;

  assign pop     = cnt_q != 2'd0;
  assign valid_o = pop;
  assign full_o  = cnt_q == 2'd2;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- design/dmrc_back.sv -----
// Back end: multiply and divide pipeline that turns a classified row into coefficients.
`default_nettype none
module dmrc_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  dmrc_pkg::item_t                      item_i,
  output logic                                 done_o,
  output logic signed [dmrc_pkg::WordBits-1:0] diag_coef_o,
  output logic signed [dmrc_pkg::WordBits-1:0] upper_coef_o,
  output logic signed [dmrc_pkg::WordBits-1:0] lower_coef_o,
  output logic                                 upper_valid_o,
  output logic                                 lower_valid_o,
  output logic                                 div_error_o
);
  localparam int WB  = dmrc_pkg::WordBits;
  localparam int MB  = dmrc_pkg::MagBits;
  localparam int PB  = dmrc_pkg::ProdBits;
  localparam int FB  = dmrc_pkg::FracBits;
  localparam int ML  = dmrc_pkg::MulLat;
  localparam int DL  = dmrc_pkg::DivLat;
  localparam int L   = dmrc_pkg::PipeLat;
  localparam int CN  = dmrc_pkg::CoupNum;
  localparam int T2  = ML - 1;
  localparam int T3  = ML + DL - 1;
  localparam int T4  = 2 * ML + DL - 1;
  localparam int DvL = DL + ML;

  dmrc_pkg::item_t pipe_q [L];
  logic            vld_q  [L];
  logic [PB-1:0]   dv_q   [DvL];

  logic [PB-1:0] p_r, p_l, p_v, p_cr, p_cl;
  logic [MB-1:0] h_r, h_l, q_r, q_l;
  logic [CN-1:0] num_r, num_l;
  logic [PB-1:0] den_r;

  dmrc_pkg::item_t it4, it5;

  dmrc_mul u_mul_r (.clk_i, .a_i(item_i.ds), .b_i(item_i.dr), .prod_o(p_r));
  dmrc_mul u_mul_l (.clk_i, .a_i(item_i.ds), .b_i(item_i.dl), .prod_o(p_l));
  dmrc_mul u_mul_v (.clk_i, .a_i(item_i.cw), .b_i(item_i.vol), .prod_o(p_v));

  dmrc_div #(.NumBits(dmrc_pkg::HarmNum), .DenBits(dmrc_pkg::HarmDen)) u_div_hr (
    .clk_i, .num_i(p_r), .den_i(pipe_q[T2].sum_r), .quo_o(h_r));
  dmrc_div #(.NumBits(dmrc_pkg::HarmNum), .DenBits(dmrc_pkg::HarmDen)) u_div_hl (
    .clk_i, .num_i(p_l), .den_i(pipe_q[T2].sum_l), .quo_o(h_l));

  dmrc_mul u_mul_cr (.clk_i, .a_i(h_r), .b_i(pipe_q[T3].ar), .prod_o(p_cr));
  dmrc_mul u_mul_cl (.clk_i, .a_i(h_l), .b_i(pipe_q[T3].al), .prod_o(p_cl));

  assign it4   = pipe_q[T4];
  assign num_r = (it4.func == dmrc_pkg::FUNC_BOUNDARY) ? (CN'(it4.b_mag) << FB)
                                                       : (CN'(p_cr) << (1 + FB));
  assign den_r = (it4.func == dmrc_pkg::FUNC_BOUNDARY) ? PB'(it4.cw) : dv_q[DvL-1];
  assign num_l = CN'(p_cl) << (1 + FB);

  dmrc_div #(.NumBits(CN), .DenBits(dmrc_pkg::CoupDen)) u_div_cr (
    .clk_i, .num_i(num_r), .den_i(den_r), .quo_o(q_r));
  dmrc_div #(.NumBits(CN), .DenBits(dmrc_pkg::CoupDen)) u_div_cl (
    .clk_i, .num_i(num_l), .den_i(dv_q[DvL-1]), .quo_o(q_l));

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= item_i;
    for (int i = 1; i < L; i++) begin
      pipe_q[i] <= pipe_q[i-1];
    end
    dv_q[0] <= p_v;
    for (int i = 1; i < DvL; i++) begin
      dv_q[i] <= dv_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < L; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < L; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  assign it5 = pipe_q[L-1];

  logic signed [WB:0] hs, qs;
  logic [WB-1:0]      s1;
  logic [WB-1:0]      diag_d, up_d, low_d;
  logic               uv_d, lv_d;

  always_comb begin
    hs = it5.a_neg ? -$signed({2'b00, it5.a_half}) : $signed({2'b00, it5.a_half});
    qs = it5.b_neg ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
    s1 = dmrc_pkg::sat_word($signed({2'b00, q_r}) + $signed({2'b00, it5.rem}));
    if (it5.func == dmrc_pkg::FUNC_BOUNDARY) begin
      diag_d = dmrc_pkg::sat_word(hs + qs);
      low_d  = dmrc_pkg::sat_word(hs - qs);
      up_d   = '0;
      uv_d   = 1'b0;
      lv_d   = 1'b1;
    end else begin
      up_d = WB'(-{1'b0, q_r});
      uv_d = 1'b1;
      if (it5.has_left) begin
        diag_d = dmrc_pkg::sat_word($signed({1'b0, s1}) + $signed({2'b00, q_l}));
        low_d  = WB'(-{1'b0, q_l});
        lv_d   = 1'b1;
      end else begin
        diag_d = s1;
        low_d  = '0;
        lv_d   = 1'b0;
      end
    end
    if (it5.err) begin
      diag_d = '0;
      up_d   = '0;
      low_d  = '0;
      uv_d   = 1'b0;
      lv_d   = 1'b0;
    end
  end

  logic          done_q;
  logic [WB-1:0] diag_q, up_q, low_q;
  logic          uv_q, lv_q, err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[L-1];
    end
  end

  always_ff @(posedge clk_i) begin
    diag_q <= diag_d;
    up_q   <= up_d;
    low_q  <= low_d;
    uv_q   <= uv_d;
    lv_q   <= lv_d;
    err_q  <= it5.err;
  end

  assign done_o        = done_q;
  assign diag_coef_o   = $signed(diag_q);
  assign upper_coef_o  = $signed(up_q);
  assign lower_coef_o  = $signed(low_q);
  assign upper_valid_o = uv_q;
  assign lower_valid_o = lv_q;
  assign div_error_o   = err_q;
endmodule
`default_nettype wire

// ----- design/diffusion_matrix_row_coefficients.sv -----
// Top level: one diffusion matrix row per word, fully pipelined.
//
// A word is taken whenever start_i is high and busy_o is low; busy_o stays low in normal
// use, so one row can enter every cycle. Each row's result is marked by done_o for one cycle,
// in acceptance order; the path runs through two chained 48-stage bit-per-stage dividers
// (harmonic mean, then face coupling), two 2-stage multipliers, the input queue and the
// output register. cell_width is written through cfg_we_i/cfg_wdata_i, which the user must
// do only while no row is in flight (the block does not enforce this); it resets to 1.0.
`default_nettype none
module diffusion_matrix_row_coefficients (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dmrc_pkg::MagBits-1:0]         cfg_wdata_i,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic                                 func_i,
  input  logic [dmrc_pkg::MagBits-1:0]         diff_self_i,
  input  logic [dmrc_pkg::MagBits-1:0]         diff_right_i,
  input  logic [dmrc_pkg::MagBits-1:0]         diff_left_i,
  input  logic [dmrc_pkg::MagBits-1:0]         removal_xs_i,
  input  logic [dmrc_pkg::MagBits-1:0]         cell_volume_i,
  input  logic [dmrc_pkg::MagBits-1:0]         area_left_i,
  input  logic [dmrc_pkg::MagBits-1:0]         area_right_i,
  input  logic                                 has_left_i,
  input  logic signed [dmrc_pkg::WordBits-1:0] bc_a_i,
  input  logic signed [dmrc_pkg::WordBits-1:0] bc_b_i,
  output logic                                 done_o,
  output logic signed [dmrc_pkg::WordBits-1:0] diag_coef_o,
  output logic signed [dmrc_pkg::WordBits-1:0] upper_coef_o,
  output logic signed [dmrc_pkg::WordBits-1:0] lower_coef_o,
  output logic                                 upper_valid_o,
  output logic                                 lower_valid_o,
  output logic                                 div_error_o
);
  localparam int Latency = dmrc_pkg::PipeLat + 2;

  logic [dmrc_pkg::MagBits-1:0] cell_width_q;
  dmrc_pkg::item_t              front_item, back_item;
  logic                         push, full, back_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_width_q <= dmrc_pkg::CellWidthReset;
    end else if (cfg_we_i) begin
      cell_width_q <= cfg_wdata_i;
    end
  end

  assign busy_o = full;
  assign push   = start_i && !full;

  dmrc_front u_front (
    .func_i, .diff_self_i, .diff_right_i, .diff_left_i, .removal_xs_i, .cell_volume_i,
    .area_left_i, .area_right_i, .has_left_i, .bc_a_i, .bc_b_i,
    .cell_width_i(cell_width_q), .item_o(front_item)
  );

  dmrc_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(front_item), .full_o(full),
    .valid_o(back_valid), .item_o(back_item)
  );

  dmrc_back u_back (
    .clk_i, .rst_ni, .valid_i(back_valid), .item_i(back_item), .done_o,
    .diag_coef_o, .upper_coef_o, .lower_coef_o, .upper_valid_o, .lower_valid_o,
    .div_error_o
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Latency done_o)
    else $error("row result missing at fixed latency");

  a_err_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && div_error_o |-> !upper_valid_o && !lower_valid_o && diag_coef_o == '0)
    else $error("error result not cleared");

  a_some_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !div_error_o |-> upper_valid_o || lower_valid_o)
    else $error("valid row writes no off-diagonal entry");
`endif
endmodule
`default_nettype wire

// ----- tb/tb_diffusion_matrix_row_coefficients.sv -----
// Self-checking testbench for the diffusion matrix row coefficient block.
`timescale 1ns / 1ps
`default_nettype none
module tb_diffusion_matrix_row_coefficients;

  localparam int Mb = dmrc_pkg::MagBits;
  localparam int Wb = dmrc_pkg::WordBits;
  localparam logic [Mb-1:0] MagMax = {Mb{1'b1}};
  localparam longint WordMax = (64'sd1 <<< (Wb - 1)) - 1;
  localparam longint WordMin = -(64'sd1 <<< (Wb - 1));
  localparam logic [Mb-1:0] One = Mb'(64'd1 << dmrc_pkg::FracBits);
  localparam int SettleCycles = dmrc_pkg::PipeLat + 20;
  localparam int StallLimit = 4 * dmrc_pkg::PipeLat + 200;

  typedef struct {
    dmrc_pkg::func_e  func;
    logic [Mb-1:0]    ds, dr, dl, rem, vol, al, ar;
    logic             has_left;
    logic [Wb-1:0]    bc_a, bc_b;
    logic             known;
  } row_t;

  typedef struct {
    logic [Wb-1:0] diag, upper, lower;
    logic          uv, lv, err;
  } coef_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [Mb-1:0] cfg_wdata_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic func_i = 1'b0;
  logic [Mb-1:0] diff_self_i = '0, diff_right_i = '0, diff_left_i = '0;
  logic [Mb-1:0] removal_xs_i = '0, cell_volume_i = '0, area_left_i = '0, area_right_i = '0;
  logic has_left_i = 1'b0;
  logic signed [Wb-1:0] bc_a_i = '0, bc_b_i = '0;
  logic done_o;
  logic signed [Wb-1:0] diag_coef_o, upper_coef_o, lower_coef_o;
  logic upper_valid_o, lower_valid_o, div_error_o;

  coef_t expected_rows[$];
  logic [Mb-1:0] cell_width = One;
  int errors = 0;
  int idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  diffusion_matrix_row_coefficients u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start_i, .busy_o,
    .func_i, .diff_self_i, .diff_right_i, .diff_left_i, .removal_xs_i,
    .cell_volume_i, .area_left_i, .area_right_i, .has_left_i, .bc_a_i, .bc_b_i,
    .done_o, .diag_coef_o, .upper_coef_o, .lower_coef_o,
    .upper_valid_o, .lower_valid_o, .div_error_o
  );

  function automatic logic [Wb-1:0] clamp_word(input longint x);
    if (x > WordMax) return Wb'(WordMax);
    if (x < WordMin) return Wb'(WordMin);
    return x[Wb-1:0];
  endfunction

  function automatic logic [Mb-1:0] face_coupling(input logic [Mb-1:0] ds, dn, area, cw, vol,
                                                  inout logic err);
    logic [Mb:0] sum;
    logic [191:0] h, num, den, q;
    sum = {1'b0, ds} + {1'b0, dn};
    if (sum == 0) begin
      err = 1'b1;
      return '0;
    end
    h = (192'(ds) * 192'(dn)) / 192'(sum);
    num = (h * 192'(area)) << (dmrc_pkg::FracBits + 1);
    den = 192'(cw) * 192'(vol);
    q = num / den;
    return (q > 192'(MagMax)) ? MagMax : q[Mb-1:0];
  endfunction

  function automatic coef_t predict_coefs(input row_t r, input logic [Mb-1:0] cw);
    coef_t c;
    logic err;
    longint cr, cl, half, quo, am, bm, d;
    logic [191:0] q;
    c = '{default: '0};
    err = 1'b0;
    if (r.func == dmrc_pkg::FUNC_INTERIOR) begin
      if (cw == 0 || r.vol == 0) begin
        err = 1'b1;
      end else begin
        cr = longint'(face_coupling(r.ds, r.dr, r.ar, cw, r.vol, err));
        c.upper = clamp_word(-cr);
        c.uv = 1'b1;
        d = cr + longint'(r.rem);
        if (r.has_left) begin
          cl = longint'(face_coupling(r.ds, r.dl, r.al, cw, r.vol, err));
          c.lower = clamp_word(-cl);
          c.lv = 1'b1;
          d = longint'(clamp_word(d)) + cl;
          d = longint'($signed(clamp_word(d)));
        end
        c.diag = clamp_word(d);
      end
    end else if (cw == 0) begin
      err = 1'b1;
    end else begin
      am = longint'($signed(r.bc_a));
      bm = longint'($signed(r.bc_b));
      half = (am < 0 ? -am : am) >>> 1;
      q = (192'(bm < 0 ? -bm : bm) << dmrc_pkg::FracBits) / 192'(cw);
      quo = (q > 192'(MagMax)) ? longint'(MagMax) : longint'(q[Mb-1:0]);
      if (am < 0) half = -half;
      if (bm < 0) quo = -quo;
      c.diag = clamp_word(half + quo);
      c.lower = clamp_word(half - quo);
      c.lv = 1'b1;
    end
    if (err) c = '{default: '0};
    c.err = err;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [Wb-1:0] got, exp);
    $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, exp);
    errors++;
  endtask

  always @(posedge clk_i) begin
    coef_t e;
    if (rst_ni && done_o) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected word", diag_coef_o, '0);
      end else begin
        e = expected_rows.pop_front();
        if (diag_coef_o !== e.diag) report_mismatch("diag_coef", diag_coef_o, e.diag);
        if (upper_coef_o !== e.upper) report_mismatch("upper_coef", upper_coef_o, e.upper);
        if (lower_coef_o !== e.lower) report_mismatch("lower_coef", lower_coef_o, e.lower);
        if (upper_valid_o !== e.uv) report_mismatch("upper_valid", Wb'(upper_valid_o), Wb'(e.uv));
        if (lower_valid_o !== e.lv) report_mismatch("lower_valid", Wb'(lower_valid_o), Wb'(e.lv));
        if (div_error_o !== e.err) report_mismatch("div_error", Wb'(div_error_o), Wb'(e.err));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("diffusion_matrix_row_coefficients test failed");
      $finish;
    end
  end

  task automatic send_row(input row_t r, input coef_t typed);
    func_i <= r.func;
    diff_self_i <= r.ds;
    diff_right_i <= r.dr;
    diff_left_i <= r.dl;
    removal_xs_i <= r.rem;
    cell_volume_i <= r.vol;
    area_left_i <= r.al;
    area_right_i <= r.ar;
    has_left_i <= r.has_left;
    bc_a_i <= r.bc_a;
    bc_b_i <= r.bc_b;
    start_i <= 1'b1;
    do @(posedge clk_i); while (!(start_i && !busy_o));
    expected_rows.push_back(r.known ? typed : predict_coefs(r, cell_width));
    if ($urandom_range(0, 3) != 0) begin
      int gap;
      gap = $urandom_range(0, 15);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_rows();
    start_i <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [Mb-1:0] w);
    drain_rows();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cell_width = w;
    @(posedge clk_i);
  endtask

  function automatic logic [Mb-1:0] rand_mag();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return MagMax;
      2, 3: return v[Mb-1:0];
      default: return v[Mb-1:0] >> $urandom_range(8, 46);
    endcase
  endfunction

  function automatic row_t rand_row();
    row_t r;
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    r.func = dmrc_pkg::func_e'($urandom_range(0, 3) == 0);
    r.ds = rand_mag();
    r.dr = rand_mag();
    r.dl = rand_mag();
    r.rem = rand_mag();
    r.vol = rand_mag();
    r.al = rand_mag();
    r.ar = rand_mag();
    r.has_left = 1'($urandom_range(0, 1));
    r.bc_a = ($urandom_range(0, 2) == 0) ? a[Wb-1:0]
                                         : Wb'($signed(a[Wb-1:0]) >>> $urandom_range(4, 46));
    r.bc_b = ($urandom_range(0, 2) == 0) ? b[Wb-1:0]
                                         : Wb'($signed(b[Wb-1:0]) >>> $urandom_range(4, 46));
    r.known = 1'b0;
    return r;
  endfunction

  row_t rows[12];
  coef_t typed[12];
  coef_t no_row = '{default: '0};
  coef_t div_zero = '{diag: '0, upper: '0, lower: '0, uv: 1'b0, lv: 1'b0, err: 1'b1};

  initial begin
    row_t r;
    rows[0] = '{dmrc_pkg::FUNC_INTERIOR, One, One, One, One, '0, One, One, 1'b1, '0, '0, 1'b1};
    typed[0] = div_zero;
    rows[1] = '{dmrc_pkg::FUNC_INTERIOR, '0, '0, One, One, One, One, One, 1'b0, '0, '0, 1'b1};
    typed[1] = div_zero;
    rows[2] = '{dmrc_pkg::FUNC_INTERIOR, '0, One, '0, One, One, One, One, 1'b1, '0, '0, 1'b1};
    typed[2] = div_zero;
    rows[3] = '{dmrc_pkg::FUNC_BOUNDARY, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, '0, 1'b1};
    typed[3] = '{diag: '0, upper: '0, lower: '0, uv: 1'b0, lv: 1'b1, err: 1'b0};
    rows[4] = '{dmrc_pkg::FUNC_INTERIOR, MagMax, MagMax, MagMax, MagMax, MagMax, MagMax,
                MagMax, 1'b1, {1'b1, {Mb{1'b0}}}, {1'b0, {Mb{1'b1}}}, 1'b0};
    rows[5] = '{dmrc_pkg::FUNC_INTERIOR, One, One, One, One, One, One, One, 1'b0, '0, '0, 1'b0};
    rows[6] = '{dmrc_pkg::FUNC_INTERIOR, One, One, One, One, One, One, One, 1'b1, '0, '0, 1'b0};
    rows[7] = '{dmrc_pkg::FUNC_BOUNDARY, '0, '0, '0, '0, '0, '0, '0, 1'b1,
                {1'b1, {Mb{1'b0}}}, {1'b0, {Mb{1'b1}}}, 1'b0};
    rows[8] = '{dmrc_pkg::FUNC_BOUNDARY, '0, '0, '0, '0, '0, '0, '0, 1'b0,
                {1'b0, {Mb{1'b1}}}, {1'b1, {Mb{1'b0}}}, 1'b0};
    rows[9] = '{dmrc_pkg::FUNC_BOUNDARY, MagMax, MagMax, MagMax, MagMax, MagMax, MagMax,
                MagMax, 1'b1, Wb'(-3), Wb'(5), 1'b0};
    rows[10] = '{dmrc_pkg::FUNC_INTERIOR, 47'd1, 47'd1, MagMax, '0, 47'd1, 47'd1, MagMax, 1'b1,
                 '0, '0, 1'b0};
    rows[11] = '{dmrc_pkg::FUNC_INTERIOR, MagMax, '0, MagMax, MagMax, One, '0, MagMax, 1'b1,
                 '0, '0, 1'b0};
    for (int i = 3; i < 12; i++) if (!rows[i].known) typed[i] = no_row;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 12; i++) send_row(rows[i], typed[i]);

    write_width('0);
    r = rows[8];
    r.known = 1'b1;
    send_row(r, div_zero);
    r = rows[5];
    r.known = 1'b1;
    send_row(r, div_zero);

    write_width(MagMax);
    for (int i = 4; i < 12; i++) send_row(rows[i], no_row);
    write_width(47'd1);
    for (int i = 4; i < 12; i++) send_row(rows[i], no_row);
    write_width(One);

    for (int n = 0; n < 1100; n++) begin
      if (n % 220 == 219) begin
        if ($urandom_range(0, 1) == 0) write_width(One >> $urandom_range(0, 24));
        else write_width(rand_mag() | 47'd1);
      end else if (n == 500) begin
        drain_rows();
      end
      send_row(rand_row(), no_row);
    end

    drain_rows();
    if (errors == 0) begin
      $display("diffusion_matrix_row_coefficients test passed");
    end else begin
      $display("diffusion_matrix_row_coefficients test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
